// ===== sv/lpi_pkg.sv =====
// ----------------------------------------------------------------------------
// lpi_pkg
// Types and widths shared by the line/plane intersection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package lpi_pkg;
   localparam int COORD_W = 32;            // coordinate width
   localparam int DIFF_W  = COORD_W + 1;   // difference of two coordinates
   localparam int PROD_W  = DIFF_W + COORD_W + 1;
   localparam int DOT_W   = PROD_W + 2;    // sum of three products
   localparam int Q_W     = COORD_W + 1;   // quotient bits resolved by the divider chain

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [DIFF_W-1:0]  diff_type;

   // State carried from one divider cell to the next
   typedef struct packed {
      logic [2:0][COORD_W-1:0] p0;
      logic [2:0][DIFF_W-1:0]  orient;
      logic [DOT_W-1:0]        den;      // divisor magnitude
      logic [DOT_W-1:0]        rem;      // partial remainder
      logic [Q_W-1:0]          num_low;  // dividend bits still to bring down
      logic [Q_W-1:0]          quo;      // quotient so far
      logic                    parallel;
      logic                    big;      // quotient known to exceed the divider range
      logic                    tneg;
   } div_type;
endpackage
`default_nettype wire

// ===== sv/lpi_if.sv =====
// ----------------------------------------------------------------------------
// lpi_req_if / lpi_rsp_if
// Valid/ready channels for queries and intersection results.
// ----------------------------------------------------------------------------
`default_nettype none
interface lpi_req_if;
   logic                valid;
   logic                ready;
   logic signed [31:0]  line_start_x, line_start_y, line_start_z;
   logic signed [31:0]  line_end_x, line_end_y, line_end_z;
   logic signed [31:0]  plane_point_x, plane_point_y, plane_point_z;
   logic signed [31:0]  normal_x, normal_y, normal_z;
   modport source (output valid, line_start_x, line_start_y, line_start_z,
                   line_end_x, line_end_y, line_end_z, plane_point_x,
                   plane_point_y, plane_point_z, normal_x, normal_y, normal_z,
                   input ready);
   modport sink   (input valid, line_start_x, line_start_y, line_start_z,
                   line_end_x, line_end_y, line_end_z, plane_point_x,
                   plane_point_y, plane_point_z, normal_x, normal_y, normal_z,
                   output ready);
endinterface

interface lpi_rsp_if;
   logic                valid;
   logic                ready;
   logic signed [31:0]  hit_x, hit_y, hit_z;
   logic                is_parallel;
   logic                overflowed;
   modport source (output valid, hit_x, hit_y, hit_z, is_parallel, overflowed,
                   input ready);
   modport sink   (input valid, hit_x, hit_y, hit_z, is_parallel, overflowed,
                   output ready);
endinterface
`default_nettype wire

// ===== sv/lpi_div_cell.sv =====
// ----------------------------------------------------------------------------
// lpi_div_cell
// One restoring division step: bring down a dividend bit, trial subtract,
// shift the quotient bit in, register the lot.
// ----------------------------------------------------------------------------
`default_nettype none
module lpi_div_cell (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            advance,
   input  wire logic            valid_in,
   input  wire lpi_pkg::div_type data_in,
   output logic                 valid_out,
   output lpi_pkg::div_type     data_out
);
   logic                       valid_ff;
   lpi_pkg::div_type           data_ff, data_next_in;
   logic [lpi_pkg::DOT_W:0]    trial;
   logic [lpi_pkg::DOT_W:0]    diff;

   always_comb begin
      data_next_in = data_in;
      trial = {data_in.rem, data_in.num_low[lpi_pkg::Q_W-1]};
      diff  = trial - {1'b0, data_in.den};
      data_next_in.num_low = {data_in.num_low[lpi_pkg::Q_W-2:0], 1'b0};
      if (trial >= {1'b0, data_in.den}) begin
         data_next_in.rem = diff[lpi_pkg::DOT_W-1:0];
         data_next_in.quo = {data_in.quo[lpi_pkg::Q_W-2:0], 1'b1};
      end else begin
         data_next_in.rem = trial[lpi_pkg::DOT_W-1:0];
         data_next_in.quo = {data_in.quo[lpi_pkg::Q_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         data_ff <= data_next_in;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;
endmodule
`default_nettype wire

// ===== sv/line_plane_intersection.sv =====
// ----------------------------------------------------------------------------
// line_plane_intersection
// Fixed-point intersection of a line through two points with a plane.
// ----------------------------------------------------------------------------
// Fully pipelined: one query per cycle, results in order. Stages in order:
// differences, products, dot sums, 33 divider cells resolving one quotient
// bit each, t saturation, t*orient products, shift/add/saturate. The chain
// of divider cells is the longest part; the whole pipe holds when a
// finished result is not taken. A parallel or degenerate line returns
// zeros with is_parallel set.
`default_nettype none
module line_plane_intersection #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lpi_req_if.sink    req_chan,
   lpi_rsp_if.source  rsp_chan
);
   localparam int CW   = lpi_pkg::COORD_W;
   localparam int DW   = lpi_pkg::DIFF_W;
   localparam int PW   = lpi_pkg::PROD_W;
   localparam int SW   = lpi_pkg::DOT_W;
   localparam int QW   = lpi_pkg::Q_W;
   localparam int NSH_W = SW + FRAC_BITS;
   localparam int HI_W  = NSH_W - QW;
   localparam int MW    = CW + DW;

   logic advance;
   logic out_valid_ff;
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   // stage 1: differences
   logic v1_ff;
   logic signed [CW-1:0] p0_1_ff [3], nrm_1_ff [3];
   logic signed [DW-1:0] ori_1_ff [3], shf_1_ff [3];
   logic signed [CW-1:0] in_p0 [3], in_p1 [3], in_q [3], in_n [3];

   assign in_p0[0] = req_chan.line_start_x;  assign in_p0[1] = req_chan.line_start_y;
   assign in_p0[2] = req_chan.line_start_z;  assign in_p1[0] = req_chan.line_end_x;
   assign in_p1[1] = req_chan.line_end_y;    assign in_p1[2] = req_chan.line_end_z;
   assign in_q[0]  = req_chan.plane_point_x; assign in_q[1]  = req_chan.plane_point_y;
   assign in_q[2]  = req_chan.plane_point_z; assign in_n[0]  = req_chan.normal_x;
   assign in_n[1]  = req_chan.normal_y;      assign in_n[2]  = req_chan.normal_z;

   // stage 2: products
   logic v2_ff;
   logic signed [CW-1:0] p0_2_ff [3];
   logic signed [DW-1:0] ori_2_ff [3];
   logic signed [PW-1:0] pn_2_ff [3], pd_2_ff [3];

   // stage 3: dot products
   logic v3_ff;
   logic signed [CW-1:0] p0_3_ff [3];
   logic signed [DW-1:0] ori_3_ff [3];
   logic signed [SW-1:0] num_3_ff, den_3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_chan.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            p0_1_ff[i]  <= in_p0[i];
            nrm_1_ff[i] <= in_n[i];
            ori_1_ff[i] <= DW'(in_p1[i]) - DW'(in_p0[i]);
            shf_1_ff[i] <= DW'(in_p0[i]) - DW'(in_q[i]);
            p0_2_ff[i]  <= p0_1_ff[i];
            ori_2_ff[i] <= ori_1_ff[i];
            pn_2_ff[i]  <= PW'(shf_1_ff[i]) * PW'(nrm_1_ff[i]);
            pd_2_ff[i]  <= PW'(ori_1_ff[i]) * PW'(nrm_1_ff[i]);
            p0_3_ff[i]  <= p0_2_ff[i];
            ori_3_ff[i] <= ori_2_ff[i];
         end
         num_3_ff <= SW'(pn_2_ff[0]) + SW'(pn_2_ff[1]) + SW'(pn_2_ff[2]);
         den_3_ff <= SW'(pd_2_ff[0]) + SW'(pd_2_ff[1]) + SW'(pd_2_ff[2]);
      end
   end

   // divider set-up: magnitudes, sign, range check on the top dividend bits
   lpi_pkg::div_type  cell_data [QW+1];
   logic              cell_valid [QW+1];
   lpi_pkg::div_type  head_data;
   logic [SW-1:0]     neg_num, abs_num, abs_den;
   logic [NSH_W-1:0]  num_sh;
   logic [HI_W-1:0]   num_hi;

   always_comb begin
      neg_num = -num_3_ff;
      abs_num = neg_num[SW-1] ? -neg_num : neg_num;
      abs_den = den_3_ff[SW-1] ? -den_3_ff : den_3_ff;
      num_sh  = {abs_num, {FRAC_BITS{1'b0}}};
      num_hi  = num_sh[NSH_W-1:QW];
      head_data.p0       = {p0_3_ff[2], p0_3_ff[1], p0_3_ff[0]};
      head_data.orient   = {ori_3_ff[2], ori_3_ff[1], ori_3_ff[0]};
      head_data.den      = abs_den;
      head_data.rem      = {{(SW-HI_W){1'b0}}, num_hi};
      head_data.num_low  = num_sh[QW-1:0];
      head_data.quo      = '0;
      head_data.parallel = (den_3_ff == '0);
      head_data.big      = ({{(SW-HI_W){1'b0}}, num_hi} >= abs_den);
      head_data.tneg     = neg_num[SW-1] != den_3_ff[SW-1];
   end

   assign cell_data[0]  = head_data;
   assign cell_valid[0] = v3_ff;

   for (genvar g = 0; g < QW; g++) begin : g_cell
      lpi_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (cell_valid[g]),
         .data_in   (cell_data[g]),
         .valid_out (cell_valid[g+1]),
         .data_out  (cell_data[g+1])
      );
   end

   // t saturation
   lpi_pkg::div_type dq;
   logic signed [CW-1:0] t_in;
   logic                 tovf_in;
   assign dq = cell_data[QW];

   always_comb begin
      t_in    = CW'(dq.quo);
      tovf_in = 1'b0;
      if (dq.big) begin
         tovf_in = 1'b1;
         t_in    = dq.tneg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else if (dq.tneg) begin
         if (dq.quo > {1'b0, 1'b1, {(CW-1){1'b0}}}) begin
            tovf_in = 1'b1;
            t_in    = {1'b1, {(CW-1){1'b0}}};
         end else begin
            t_in = CW'(-dq.quo);
         end
      end else if (dq.quo[QW-1:CW-1] != '0) begin
         tovf_in = 1'b1;
         t_in    = {1'b0, {(CW-1){1'b1}}};
      end
   end

   logic v5_ff, v6_ff;
   logic signed [CW-1:0] t_5_ff, p0_5_ff [3], p0_6_ff [3];
   logic signed [DW-1:0] ori_5_ff [3];
   logic signed [MW-1:0] prod_6_ff [3];
   logic ovf_5_ff, par_5_ff, ovf_6_ff, par_6_ff;

   // final shift, add and clamp
   logic signed [MW-1:0]   sh_c [3];
   logic signed [MW:0]     sum_c [3];
   logic signed [CW-1:0]   hit_c [3];
   logic                   ovf_c;

   always_comb begin
      ovf_c = ovf_6_ff;
      for (int i = 0; i < 3; i++) begin
         sh_c[i]  = prod_6_ff[i] >>> FRAC_BITS;
         sum_c[i] = (MW+1)'(sh_c[i]) + (MW+1)'(p0_6_ff[i]);
         if (sum_c[i] > (MW+1)'(signed'({1'b0, {(CW-1){1'b1}}}))) begin
            hit_c[i] = {1'b0, {(CW-1){1'b1}}};
            ovf_c    = 1'b1;
         end else if (sum_c[i] < (MW+1)'(signed'({1'b1, {(CW-1){1'b0}}}))) begin
            hit_c[i] = {1'b1, {(CW-1){1'b0}}};
            ovf_c    = 1'b1;
         end else begin
            hit_c[i] = CW'(sum_c[i]);
         end
         if (par_6_ff) begin
            hit_c[i] = '0;
         end
      end
      if (par_6_ff) begin
         ovf_c = 1'b0;
      end
   end

   logic signed [CW-1:0] hit_ff [3];
   logic par_ff, ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         v5_ff        <= cell_valid[QW];
         v6_ff        <= v5_ff;
         out_valid_ff <= v6_ff;
      end
      if (advance) begin
         t_5_ff   <= t_in;
         ovf_5_ff <= tovf_in;
         par_5_ff <= dq.parallel;
         for (int i = 0; i < 3; i++) begin
            p0_5_ff[i]   <= signed'(dq.p0[i]);
            ori_5_ff[i]  <= signed'(dq.orient[i]);
            p0_6_ff[i]   <= p0_5_ff[i];
            prod_6_ff[i] <= MW'(t_5_ff) * MW'(ori_5_ff[i]);
            hit_ff[i]    <= hit_c[i];
         end
         ovf_6_ff <= ovf_5_ff;
         par_6_ff <= par_5_ff;
         par_ff   <= par_6_ff;
         ovf_ff   <= ovf_c;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.hit_x       = hit_ff[0];
   assign rsp_chan.hit_y       = hit_ff[1];
   assign rsp_chan.hit_z       = hit_ff[2];
   assign rsp_chan.is_parallel = par_ff;
   assign rsp_chan.overflowed  = ovf_ff;

   // a parallel result carries zeros and no overflow
   a_parallel_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && par_ff |-> hit_ff[0] == '0 && hit_ff[1] == '0
                                 && hit_ff[2] == '0 && !ovf_ff)
      else $error("parallel result not cleared");

   // input holds only while a result is waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> out_valid_ff && !rsp_chan.ready)
      else $error("stall without pending result");

   // after the last cell the remainder lies below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cell_valid[QW] && !dq.parallel && !dq.big |-> dq.rem < dq.den)
      else $error("divider remainder out of range");
endmodule
`default_nettype wire
